[src/assert_macros.svh]
// assertion helpers used by the checker file ohlc_chk.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication in the same cycle, masked while reset is low
`define OHLC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ohlc assertion failed");

// implication into the next cycle, masked while reset is low
`define OHLC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ohlc assertion failed");

// implication into the next cycle, always active
`define OHLC_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("ohlc assertion failed");

`endif

[src/ohlc_pkg.sv]
// ----------------------------------------------------------------------------
// ohlc_pkg
// widths, command types and constants shared by the bar aggregator
// ----------------------------------------------------------------------------
package ohlc_pkg;

  localparam int TIME_BITS   = 40;
  localparam int PRICE_BITS  = 40;
  localparam int VOLUME_BITS = 48;
  localparam int SIZE_BITS   = 32;
  localparam int PERIOD_BITS = 17;
  localparam int CNT_BITS    = $clog2(TIME_BITS);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = PERIOD_BITS'(60);

  typedef enum logic {
    OP_NEW,
    OP_UPDATE
  } bar_op_t;

  typedef struct packed {
    bar_op_t                op;
    logic [TIME_BITS-1:0]   start_time;
    logic [PRICE_BITS-1:0]  price;
    logic [SIZE_BITS-1:0]   size;
  } bar_cmd_t;

endpackage

[src/tick_if.sv]
// ----------------------------------------------------------------------------
// tick_if
// valid/ready channel carrying one trade tick
// ----------------------------------------------------------------------------
interface tick_if import ohlc_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [TIME_BITS-1:0]   tick_time;
  logic [PRICE_BITS-1:0]  tick_price;
  logic [SIZE_BITS-1:0]   tick_size;

  modport source (output valid, output tick_time, output tick_price, output tick_size,
                  input ready);
  modport sink   (input valid, input tick_time, input tick_price, input tick_size,
                  output ready);
endinterface

[src/bar_if.sv]
// ----------------------------------------------------------------------------
// bar_if
// valid/ready channel carrying one closed ohlcv bar
// ----------------------------------------------------------------------------
interface bar_if import ohlc_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [TIME_BITS-1:0]    bar_start_time;
  logic [PRICE_BITS-1:0]   bar_open;
  logic [PRICE_BITS-1:0]   bar_high;
  logic [PRICE_BITS-1:0]   bar_low;
  logic [PRICE_BITS-1:0]   bar_close;
  logic [VOLUME_BITS-1:0]  bar_volume;

  modport source (output valid, output bar_start_time, output bar_open, output bar_high,
                  output bar_low, output bar_close, output bar_volume, input ready);
  modport sink   (input valid, input bar_start_time, input bar_open, input bar_high,
                  input bar_low, input bar_close, input bar_volume, output ready);
endinterface

[src/ohlc_bar_aggregator.sv]
// Trade ticks come in on in_tick and closed OHLCV bars leave on out_bar. The front end
// accepts a tick, finds its period index and remainder in the radix-2 divider, then
// classifies and queues it. The bar update behind a two-entry queue applies one tick per
// cycle unless a closed bar waits on out_bar, so the divider sets the rate. The first
// tick after reset only fixes the starting period and gives no bar; a later period's first
// tick opens a bar that a still later one closes. cfg_wdata sets the period in seconds
// (reset 60, zero acts as one); the user writes it only while the block is idle (unenforced).
// ----------------------------------------------------------------------------
// ohlc_bar_aggregator
// time-bar ohlcv aggregation of a trade tick stream
// ----------------------------------------------------------------------------
module ohlc_bar_aggregator import ohlc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [PERIOD_BITS-1:0]  cfg_wdata,
  tick_if.sink                    in_tick,
  bar_if.source                   out_bar
);

  logic      push_valid;
  logic      push_ready;
  bar_cmd_t  push_cmd;
  logic      pop_valid;
  logic      pop_ready;
  bar_cmd_t  pop_cmd;

  ohlc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tick    (in_tick),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  ohlc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  ohlc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd),
    .out_bar   (out_bar)
  );

endmodule

[src/ohlc_front.sv]
// ----------------------------------------------------------------------------
// ohlc_front
// accepts ticks, divides time by the period and classifies each tick
// ----------------------------------------------------------------------------
module ohlc_front import ohlc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [PERIOD_BITS-1:0]  cfg_wdata,
  tick_if.sink                    in_tick,
  output logic                    push_valid,
  input  logic                    push_ready,
  output bar_cmd_t                push_cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_PUSH
  } state_t;

  state_t                  state_r;
  logic [CNT_BITS-1:0]     cnt_r;
  logic [TIME_BITS-1:0]    quo_r;
  logic [PERIOD_BITS:0]    rem_r;
  logic [PERIOD_BITS-1:0]  div_r;
  logic [PERIOD_BITS-1:0]  period_r;
  logic [TIME_BITS-1:0]    time_r;
  logic [PRICE_BITS-1:0]   price_r;
  logic [SIZE_BITS-1:0]    size_r;
  logic                    known_r;
  logic [TIME_BITS-1:0]    cur_period_r;

  logic [PERIOD_BITS:0]    rem_sh;
  logic                    rem_ge;
  logic [PERIOD_BITS:0]    rem_nxt;
  logic                    is_new;

  assign rem_sh  = {rem_r[PERIOD_BITS-1:0], quo_r[TIME_BITS-1]};
  assign rem_ge  = (rem_sh >= {1'b0, div_r});
  assign rem_nxt = rem_ge ? (rem_sh - {1'b0, div_r}) : rem_sh;
  assign is_new  = (quo_r > cur_period_r);

  assign in_tick.ready       = (state_r == S_IDLE);
  assign push_valid          = (state_r == S_PUSH) && known_r;
  assign push_cmd.op         = is_new ? OP_NEW : OP_UPDATE;
  assign push_cmd.start_time = time_r - {{(TIME_BITS-PERIOD_BITS-1){1'b0}}, rem_r};
  assign push_cmd.price      = price_r;
  assign push_cmd.size       = size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      period_r     <= PERIOD_RESET;
      known_r      <= 1'b0;
      cur_period_r <= '0;
    end else begin
      if (cfg_we) begin
        period_r <= cfg_wdata;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tick.valid) begin
            quo_r   <= in_tick.tick_time;
            time_r  <= in_tick.tick_time;
            price_r <= in_tick.tick_price;
            size_r  <= in_tick.tick_size;
            rem_r   <= '0;
            cnt_r   <= '0;
            div_r   <= (period_r == '0) ? PERIOD_BITS'(1) : period_r;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          rem_r <= rem_nxt;
          quo_r <= {quo_r[TIME_BITS-2:0], rem_ge};
          cnt_r <= cnt_r + CNT_BITS'(1);
          if (cnt_r == CNT_BITS'(TIME_BITS-1)) begin
            state_r <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (!known_r) begin
            known_r      <= 1'b1;
            cur_period_r <= quo_r;
            state_r      <= S_IDLE;
          end else if (push_ready) begin
            if (is_new) begin
              cur_period_r <= quo_r;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

[src/ohlc_queue.sv]
// ----------------------------------------------------------------------------
// ohlc_queue
// small fifo of classified tick commands between front and back
// ----------------------------------------------------------------------------
module ohlc_queue import ohlc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  output logic      push_ready,
  input  bar_cmd_t  push_cmd,
  output logic      pop_valid,
  input  logic      pop_ready,
  output bar_cmd_t  pop_cmd
);

  bar_cmd_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]  wr_ptr_r;
  logic [QPTR_BITS-1:0]  rd_ptr_r;
  logic [QPTR_BITS:0]    count_r;
  logic                  do_push;
  logic                  do_pop;

  assign push_ready = (count_r != (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + (QPTR_BITS+1)'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - (QPTR_BITS+1)'(1);
      end
    end
  end

endmodule

[src/ohlc_back.sv]
// ----------------------------------------------------------------------------
// ohlc_back
// holds the open bar, applies commands and registers closed bars
// ----------------------------------------------------------------------------
module ohlc_back import ohlc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      pop_valid,
  output logic      pop_ready,
  input  bar_cmd_t  pop_cmd,
  bar_if.source     out_bar
);

  logic                    open_r;
  logic [TIME_BITS-1:0]    cur_start_r;
  logic [PRICE_BITS-1:0]   cur_open_r;
  logic [PRICE_BITS-1:0]   cur_high_r;
  logic [PRICE_BITS-1:0]   cur_low_r;
  logic [PRICE_BITS-1:0]   cur_close_r;
  logic [VOLUME_BITS-1:0]  cur_vol_r;

  logic                    out_valid_r;
  logic [TIME_BITS-1:0]    out_start_r;
  logic [PRICE_BITS-1:0]   out_open_r;
  logic [PRICE_BITS-1:0]   out_high_r;
  logic [PRICE_BITS-1:0]   out_low_r;
  logic [PRICE_BITS-1:0]   out_close_r;
  logic [VOLUME_BITS-1:0]  out_vol_r;

  logic                    out_free;
  logic                    take;
  logic                    emit;
  logic                    is_new;
  logic [VOLUME_BITS:0]    vol_sum;
  logic [VOLUME_BITS-1:0]  vol_nxt;

  assign is_new    = (pop_cmd.op == OP_NEW);
  assign out_free  = !out_valid_r || out_bar.ready;
  assign pop_ready = !is_new || !open_r || out_free;
  assign take      = pop_valid && pop_ready;
  assign emit      = take && is_new && open_r;

  assign vol_sum = {1'b0, cur_vol_r} + (VOLUME_BITS+1)'(pop_cmd.size);
  assign vol_nxt = vol_sum[VOLUME_BITS] ? '1 : vol_sum[VOLUME_BITS-1:0];

  assign out_bar.valid          = out_valid_r;
  assign out_bar.bar_start_time = out_start_r;
  assign out_bar.bar_open       = out_open_r;
  assign out_bar.bar_high       = out_high_r;
  assign out_bar.bar_low        = out_low_r;
  assign out_bar.bar_close      = out_close_r;
  assign out_bar.bar_volume     = out_vol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (take && is_new) begin
        open_r <= 1'b1;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_bar.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_start_r <= cur_start_r;
      out_open_r  <= cur_open_r;
      out_high_r  <= cur_high_r;
      out_low_r   <= cur_low_r;
      out_close_r <= cur_close_r;
      out_vol_r   <= cur_vol_r;
    end
    if (take) begin
      if (is_new) begin
        cur_start_r <= pop_cmd.start_time;
        cur_open_r  <= pop_cmd.price;
        cur_high_r  <= pop_cmd.price;
        cur_low_r   <= pop_cmd.price;
        cur_close_r <= pop_cmd.price;
        cur_vol_r   <= VOLUME_BITS'(pop_cmd.size);
      end else if (open_r) begin
        cur_close_r <= pop_cmd.price;
        cur_vol_r   <= vol_nxt;
        if (pop_cmd.price < cur_low_r) begin
          cur_low_r <= pop_cmd.price;
        end else if (pop_cmd.price > cur_high_r) begin
          cur_high_r <= pop_cmd.price;
        end
      end
    end
  end

endmodule

[src/ohlc_chk.sv]
// ----------------------------------------------------------------------------
// ohlc_chk
// port-level checks on closed bars, bound to the aggregator
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ohlc_chk import ohlc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic [TIME_BITS-1:0]    bar_start_time,
  input  logic [PRICE_BITS-1:0]   bar_open,
  input  logic [PRICE_BITS-1:0]   bar_high,
  input  logic [PRICE_BITS-1:0]   bar_low,
  input  logic [PRICE_BITS-1:0]   bar_close,
  input  logic [VOLUME_BITS-1:0]  bar_volume
);

  // a stalled bar stays valid and keeps its start time, volume and close
  `OHLC_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(bar_start_time) && $stable(bar_volume) && $stable(bar_close))

  // high never below low
  `OHLC_ASSERT_IMP(a_high_low, clk, rst_n, out_valid, bar_high >= bar_low)

  // open price lies inside the range
  `OHLC_ASSERT_IMP(a_open_range, clk, rst_n, out_valid, bar_open >= bar_low && bar_open <= bar_high)

  // close price lies inside the range
  `OHLC_ASSERT_IMP(a_close_range, clk, rst_n, out_valid, bar_close >= bar_low && bar_close <= bar_high)

  // no bar right after reset
  `OHLC_ASSERT_NXT_ALWAYS(a_reset_quiet, clk, !rst_n, !out_valid)

endmodule

bind ohlc_bar_aggregator ohlc_chk u_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_bar.valid),
  .out_ready      (out_bar.ready),
  .bar_start_time (out_bar.bar_start_time),
  .bar_open       (out_bar.bar_open),
  .bar_high       (out_bar.bar_high),
  .bar_low        (out_bar.bar_low),
  .bar_close      (out_bar.bar_close),
  .bar_volume     (out_bar.bar_volume)
);
